// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; clk and rst_n must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Sampled on clk, disabled while rst_n is low.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Sampled on clk, active through reset as well.
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

  localparam logic [1:0] FUNC_FIND  = 2'd0;
  localparam logic [1:0] FUNC_ALLOC = 2'd1;
  localparam logic [1:0] FUNC_FREE  = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_RANGE  = 2'd1;
  localparam logic [1:0] STATUS_NOFREE = 2'd2;

  localparam logic [1:0] REG_BASE_OFFSET = 2'd0;
  localparam logic [1:0] REG_BITMAP_BITS = 2'd1;
  localparam logic [1:0] REG_USED_BLOCKS = 2'd2;

  localparam logic [31:0] RST_BASE_OFFSET = 32'd0;
  localparam logic [18:0] RST_BITMAP_BITS = 19'd262144;
  localparam logic [3:0]  RST_USED_BLOCKS = 4'd8;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator.sv =====
// Free-space bitmap allocator. After reset the block sweeps its bitmap memory to zero,
// one word per cycle (all WORDS_PER_BLOCK * MAX_BLOCKS words, 4096 by default), and holds
// in_stall high meanwhile; register writes are taken throughout. Mark allocated / mark
// free make one read and one write-back of the bitmap word on the single-port memory
// (no write-back when the index is out of range), then register the result. Find free
// tests one 64-bit word at a time (memory read, then mask and test). A stalled result
// holds the next transaction off until it drains.
// Configuration is read by APB at byte address 4 * index.
`default_nettype none

module bitmap_block_allocator #(
  parameter int WORDS_PER_BLOCK = 512,
  parameter int MAX_BLOCKS      = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_block_index,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_found_index,
  output logic [1:0]       out_status,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int TOTAL_WORDS = WORDS_PER_BLOCK * MAX_BLOCKS;
  localparam int TOTAL_BITS  = TOTAL_WORDS * 64;
  localparam int AW   = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
  localparam int BW   = AW + 6;
  localparam int CW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int WCW  = $clog2(WORDS_PER_BLOCK + 1);
  localparam int UBW  = ($clog2(MAX_BLOCKS + 1) > 4) ? $clog2(MAX_BLOCKS + 1) : 4;
  localparam int CMPW = (BW > 19) ? BW : 19;

  localparam logic [1:0] REG_BASE_OFFSET_IDX = bba_pkg::REG_BASE_OFFSET;
  localparam logic [1:0] REG_BITMAP_BITS_IDX = bba_pkg::REG_BITMAP_BITS;
  localparam logic [1:0] REG_USED_BLOCKS_IDX = bba_pkg::REG_USED_BLOCKS;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_MCHK,
    ST_MWR,
    ST_SBLK,
    ST_SEV,
    ST_SENC,
    ST_DONE
  } state_t;

  function automatic logic [5:0] lsb_index(input logic [63:0] v);
    logic [63:0] x;
    logic [5:0]  n;
    x = v;
    n = '0;
    if (x[31:0] == 32'd0) begin n[5] = 1'b1; x = x >> 32; end
    if (x[15:0] == 16'd0) begin n[4] = 1'b1; x = x >> 16; end
    if (x[7:0] == 8'd0) begin n[3] = 1'b1; x = x >> 8; end
    if (x[3:0] == 4'd0) begin n[2] = 1'b1; x = x >> 4; end
    if (x[1:0] == 2'd0) begin n[1] = 1'b1; x = x >> 2; end
    if (x[0] == 1'b0) begin n[0] = 1'b1; end
    return n;
  endfunction

  function automatic logic [AW-1:0] blk_base(input logic [CW-1:0] b);
    return AW'(32'(b) * WORDS_PER_BLOCK);
  endfunction

  function automatic logic [CW-1:0] blk_of(input logic [AW-1:0] a);
    logic [CW-1:0] b;
    b = '0;
    for (int k = 1; k < MAX_BLOCKS; k++) begin
      if ({1'b0, a} >= (AW+1)'(k * WORDS_PER_BLOCK)) b = CW'(k);
    end
    return b;
  endfunction

  logic [63:0] mem [TOTAL_WORDS];
  logic [63:0] rdata_r;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [63:0]   mem_wdata;

  state_t state_r, state_nxt;
  logic [31:0]   base_offset_r, base_offset_nxt;
  logic [18:0]   bitmap_bits_r, bitmap_bits_nxt;
  logic [3:0]    used_blocks_r, used_blocks_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] blk_r, blk_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic [UBW-1:0] it_r, it_nxt;
  logic [AW-1:0] waddr_r, waddr_nxt;
  logic [WCW-1:0] wcnt_r, wcnt_nxt;
  logic [5:0]    bit_r, bit_nxt;
  logic          set_r, set_nxt;
  logic [31:0]   idx_r, idx_nxt;
  logic [63:0]   free_r, free_nxt;
  logic [31:0]   res_found_r, res_found_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_found_r, out_found_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  logic [UBW-1:0] ub;
  logic [CW-1:0]  start_blk;
  logic [CW-1:0]  next_blk;
  logic [BW-1:0]  bit_base;
  logic [CMPW-1:0] lim;
  logic [63:0]    vmask;
  logic [63:0]    freebits;
  logic [31:0]    rel;
  logic           rel_ok;
  logic [63:0]    bitsel;
  logic           cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_BASE_OFFSET_IDX: prdata = base_offset_r;
      REG_BITMAP_BITS_IDX: prdata = {13'd0, bitmap_bits_r};
      REG_USED_BLOCKS_IDX: prdata = {28'd0, used_blocks_r};
      default:             prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (used_blocks_r == 4'd0) begin
      ub = UBW'(1);
    end else if (UBW'(used_blocks_r) > UBW'(MAX_BLOCKS)) begin
      ub = UBW'(MAX_BLOCKS);
    end else begin
      ub = UBW'(used_blocks_r);
    end
    start_blk = (UBW'(cursor_r) < ub) ? cursor_r : '0;
    next_blk  = ((UBW'(blk_r) + UBW'(1)) == ub) ? '0 : CW'(UBW'(blk_r) + UBW'(1));
    bit_base  = {waddr_r, 6'd0};
    lim       = CMPW'(bitmap_bits_r) - CMPW'(bit_base);
    vmask     = (lim < CMPW'(64)) ? ~({64{1'b1}} << lim[5:0]) : {64{1'b1}};
    freebits  = ~rdata_r & vmask;
    rel       = idx_r - base_offset_r;
    rel_ok    = (rel < {13'd0, bitmap_bits_r}) && (rel < 32'(TOTAL_BITS));
    bitsel    = 64'd1 << bit_r;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = waddr_r;
    case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_MCHK: begin
        mem_addr = rel[BW-1:6];
      end
      ST_MWR: begin
        mem_we    = 1'b1;
        mem_wdata = set_r ? (rdata_r | bitsel) : (rdata_r & ~bitsel);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_r <= mem[mem_addr];
  end

  always_comb begin
    state_nxt       = state_r;
    base_offset_nxt = base_offset_r;
    bitmap_bits_nxt = bitmap_bits_r;
    used_blocks_nxt = used_blocks_r;
    cursor_nxt      = cursor_r;
    blk_nxt         = blk_r;
    start_nxt       = start_r;
    it_nxt          = it_r;
    waddr_nxt       = waddr_r;
    wcnt_nxt        = wcnt_r;
    bit_nxt         = bit_r;
    set_nxt         = set_r;
    idx_nxt         = idx_r;
    free_nxt        = free_r;
    res_found_nxt   = res_found_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r;
    out_found_nxt   = out_found_r;
    out_status_nxt  = out_status_r;

    if (cfg_wr) begin
      case (paddr[3:2])
        REG_BASE_OFFSET_IDX: base_offset_nxt = pwdata;
        REG_BITMAP_BITS_IDX: bitmap_bits_nxt = pwdata[18:0];
        REG_USED_BLOCKS_IDX: used_blocks_nxt = pwdata[3:0];
        default: begin
        end
      endcase
    end

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_CLR: begin
        waddr_nxt = waddr_r + AW'(1);
        if (waddr_r == AW'(TOTAL_WORDS - 1)) begin
          waddr_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          idx_nxt = in_block_index;
          case (in_func)
            bba_pkg::FUNC_FIND: begin
              blk_nxt   = start_blk;
              start_nxt = start_blk;
              it_nxt    = '0;
              waddr_nxt = blk_base(start_blk);
              wcnt_nxt  = '0;
              state_nxt = ST_SBLK;
            end
            bba_pkg::FUNC_ALLOC: begin
              set_nxt   = 1'b1;
              state_nxt = ST_MCHK;
            end
            bba_pkg::FUNC_FREE: begin
              set_nxt   = 1'b0;
              state_nxt = ST_MCHK;
            end
            default: begin
              res_found_nxt  = '0;
              res_status_nxt = bba_pkg::STATUS_OK;
              state_nxt      = ST_DONE;
            end
          endcase
        end
      end
      ST_MCHK: begin
        if (rel_ok) begin
          waddr_nxt = rel[BW-1:6];
          bit_nxt   = rel[5:0];
          state_nxt = ST_MWR;
        end else begin
          res_found_nxt  = '0;
          res_status_nxt = bba_pkg::STATUS_RANGE;
          state_nxt      = ST_DONE;
        end
      end
      ST_MWR: begin
        cursor_nxt     = blk_of(waddr_r);
        res_found_nxt  = '0;
        res_status_nxt = bba_pkg::STATUS_OK;
        state_nxt      = ST_DONE;
      end
      ST_SBLK: begin
        if (wcnt_r == WCW'(WORDS_PER_BLOCK) || CMPW'(bit_base) >= CMPW'(bitmap_bits_r)) begin
          if ((it_r + UBW'(1)) == ub) begin
            cursor_nxt     = start_r;
            res_found_nxt  = '0;
            res_status_nxt = bba_pkg::STATUS_NOFREE;
            state_nxt      = ST_DONE;
          end else begin
            blk_nxt   = next_blk;
            it_nxt    = it_r + UBW'(1);
            waddr_nxt = blk_base(next_blk);
            wcnt_nxt  = '0;
          end
        end else begin
          state_nxt = ST_SEV;
        end
      end
      ST_SEV: begin
        if (freebits != 64'd0) begin
          free_nxt  = freebits;
          state_nxt = ST_SENC;
        end else begin
          waddr_nxt = waddr_r + AW'(1);
          wcnt_nxt  = wcnt_r + WCW'(1);
          state_nxt = ST_SBLK;
        end
      end
      ST_SENC: begin
        cursor_nxt     = blk_r;
        res_found_nxt  = base_offset_r + 32'(bit_base) + 32'(lsb_index(free_r));
        res_status_nxt = bba_pkg::STATUS_OK;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      base_offset_r <= bba_pkg::RST_BASE_OFFSET;
      bitmap_bits_r <= bba_pkg::RST_BITMAP_BITS;
      used_blocks_r <= bba_pkg::RST_USED_BLOCKS;
      cursor_r      <= '0;
      blk_r         <= '0;
      start_r       <= '0;
      it_r          <= '0;
      waddr_r       <= '0;
      wcnt_r        <= '0;
      set_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      base_offset_r <= base_offset_nxt;
      bitmap_bits_r <= bitmap_bits_nxt;
      used_blocks_r <= used_blocks_nxt;
      cursor_r      <= cursor_nxt;
      blk_r         <= blk_nxt;
      start_r       <= start_nxt;
      it_r          <= it_nxt;
      waddr_r       <= waddr_nxt;
      wcnt_r        <= wcnt_nxt;
      set_r         <= set_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    bit_r        <= bit_nxt;
    idx_r        <= idx_nxt;
    free_r       <= free_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found_index = out_found_r;
  assign out_status      = out_status_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bba_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module bba_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_found_index,
  input wire logic [1:0]  out_status
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending_r;
  logic [1:0] pending_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) pending_nxt = pending_r + 2'd1;
    if (!in_acc && out_acc) pending_nxt = pending_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // one transaction in the output register, at most one more in flight
  `BBA_ASSERT(a_no_overrun, pending_r != 2'd3, "more than two transactions in flight")
  `BBA_ASSERT(a_no_spurious, out_valid |-> pending_r != 2'd0, "result without a request")
  `BBA_ASSERT(a_err_zero, out_valid && out_status != bba_pkg::STATUS_OK |-> out_found_index == 32'd0, "error result carries an index")
  `BBA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_found_index) && $stable(out_status), "stalled result changed")
  `BBA_ASSERT_ALWAYS(a_clr_stall, $past(!rst_n) && rst_n |-> in_stall, "input taken during bitmap clear")

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_found_index (out_found_index),
  .out_status      (out_status)
);

`default_nettype wire
